@@ rtl/core/positional_sequence_store_unit_macros.svh @@
// ----------------------------------------------------------------------------
// positional_sequence_store_unit_macros.svh
// Assertion macros shared by the positional sequence store checker.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_SEQUENCE_STORE_UNIT_MACROS_SVH
`define POSITIONAL_SEQUENCE_STORE_UNIT_MACROS_SVH

// Clocked assertion, inactive while reset is high.
`define PSS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define PSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/pss_pkg.sv @@
// ----------------------------------------------------------------------------
// pss_pkg
// Shared codes, widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

  localparam int KIND_W      = 2;
  localparam int POS_W       = 16;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int MOD_CNT_W   = $clog2(POS_W);

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_DATA_WIDTH = 32;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // sources for the target position register
  localparam logic [1:0] AT_CLAMP = 2'd0;
  localparam logic [1:0] AT_LAST  = 2'd1;
  localparam logic [1:0] AT_HEAD  = 2'd2;
  localparam logic [1:0] AT_REM   = 2'd3;

  // sources for the walk index register
  localparam logic IDX_COUNT = 1'b0;
  localparam logic IDX_AT    = 1'b1;

  typedef struct packed {
    logic                capture;
    logic                at_load;
    logic [1:0]          at_src;
    logic                idx_load;
    logic                idx_src;
    logic                mod_start;
    logic                mod_step;
    logic                shift_up;
    logic                shift_dn;
    logic                write_value;
    logic                read_at;
    logic                count_inc;
    logic                count_dec;
    logic                count_clear;
    logic                load_result;
    logic                use_rdata;
    logic [STATUS_W-1:0] status;
  } pss_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              pos_neg;
    logic              pos_pos;
    logic              count_zero;
    logic              full;
    logic              up_done;
    logic              dn_done;
    logic              mod_done;
  } pss_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/positional_sequence_store_unit.sv @@
// ----------------------------------------------------------------------------
// positional_sequence_store_unit
// Ordered store of up to CAPACITY words with insert, remove, read and clear.
// ----------------------------------------------------------------------------
// One transaction at a time; every operation returns one result. Clear and
// rejected operations go straight to the result; insert at position k moves
// the entries from the tail down to k, one entry moved per cycle
// through the entry memory, reading one entry while writing the previous;
// remove with a positive position first runs the bit-serial remainder over
// the 16 position bits and the load of its result, then moves the entries;
// other removes take the tail; read also runs the remainder, but not for a
// negative position, which reads the head. A
// new transaction is taken while the previous result still waits in the
// output register. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_sequence_store_unit
  import pss_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [KIND_W-1:0]        kind,
  input  wire logic signed [POS_W-1:0]  position,
  input  wire logic [VALUE_W-1:0]       value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [VALUE_W-1:0]            read_value,
  output logic [STATUS_W-1:0]           status,
  output logic [COUNT_OUT_W-1:0]        element_count,
  output logic                          is_empty
);

  pss_cmd_t  cmd;
  pss_stat_t stat;

  pss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pss_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .kind          (kind),
    .position      (position),
    .value         (value),
    .read_value    (read_value),
    .status        (status),
    .element_count (element_count),
    .is_empty      (is_empty)
  );

endmodule

`default_nettype wire

@@ rtl/core/pss_ctrl.sv @@
// ----------------------------------------------------------------------------
// pss_ctrl
// Sequencer: decodes the operation, runs the remainder and shift walks,
// and owns the input/output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_ctrl
  import pss_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire pss_stat_t stat,
  output pss_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECIDE    = 4'd1;
  localparam logic [3:0] S_MOD       = 4'd2;
  localparam logic [3:0] S_MODSET    = 4'd3;
  localparam logic [3:0] S_SHIFT_UP  = 4'd4;
  localparam logic [3:0] S_SHIFT_DN  = 4'd5;
  localparam logic [3:0] S_FLUSH     = 4'd6;
  localparam logic [3:0] S_FINISH    = 4'd7;
  localparam logic [3:0] S_READ_WAIT = 4'd8;
  localparam logic [3:0] S_OUT       = 4'd9;

  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [STATUS_W-1:0] st_code;
  logic [STATUS_W-1:0] st_code_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    state_next   = state;
    st_code_next = st_code;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (stat.kind)
          KIND_CLEAR: begin
            cmd.count_clear = 1'b1;
            st_code_next    = ST_OK;
            state_next      = S_OUT;
          end
          KIND_INSERT: begin
            if (stat.full) begin
              st_code_next = ST_FULL;
              state_next   = S_OUT;
            end else begin
              cmd.at_load  = 1'b1;
              cmd.at_src   = AT_CLAMP;
              cmd.idx_load = 1'b1;
              cmd.idx_src  = IDX_COUNT;
              st_code_next = ST_OK;
              state_next   = S_SHIFT_UP;
            end
          end
          KIND_REMOVE: begin
            if (stat.count_zero) begin
              st_code_next = ST_EMPTY;
              state_next   = S_OUT;
            end else if (stat.pos_pos) begin
              cmd.mod_start = 1'b1;
              st_code_next  = ST_OK;
              state_next    = S_MOD;
            end else begin
              cmd.at_load  = 1'b1;
              cmd.at_src   = AT_LAST;
              cmd.idx_load = 1'b1;
              cmd.idx_src  = IDX_AT;
              st_code_next = ST_OK;
              state_next   = S_SHIFT_DN;
            end
          end
          default: begin
            if (stat.count_zero) begin
              st_code_next = ST_EMPTY;
              state_next   = S_OUT;
            end else if (!stat.pos_neg) begin
              cmd.mod_start = 1'b1;
              st_code_next  = ST_OK;
              state_next    = S_MOD;
            end else begin
              cmd.at_load  = 1'b1;
              cmd.at_src   = AT_HEAD;
              st_code_next = ST_OK;
              state_next   = S_FINISH;
            end
          end
        endcase
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_done) begin
          state_next = S_MODSET;
        end
      end
      S_MODSET: begin
        cmd.at_load  = 1'b1;
        cmd.at_src   = AT_REM;
        cmd.idx_load = 1'b1;
        cmd.idx_src  = IDX_AT;
        state_next   = (stat.kind == KIND_REMOVE) ? S_SHIFT_DN : S_FINISH;
      end
      S_SHIFT_UP: begin
        if (stat.up_done) begin
          state_next = S_FLUSH;
        end else begin
          cmd.shift_up = 1'b1;
        end
      end
      S_SHIFT_DN: begin
        if (stat.dn_done) begin
          state_next = S_FLUSH;
        end else begin
          cmd.shift_dn = 1'b1;
        end
      end
      // last pending move has already been written by here
      S_FLUSH: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        case (stat.kind)
          KIND_INSERT: begin
            cmd.write_value = 1'b1;
            cmd.count_inc   = 1'b1;
            state_next      = S_OUT;
          end
          KIND_REMOVE: begin
            cmd.count_dec = 1'b1;
            state_next    = S_OUT;
          end
          default: begin
            cmd.read_at = 1'b1;
            state_next  = S_READ_WAIT;
          end
        endcase
      end
      S_READ_WAIT: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_result = 1'b1;
          cmd.use_rdata   = (stat.kind == KIND_READ) && (st_code == ST_OK);
          cmd.status      = st_code;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      st_code   <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      st_code <= st_code_next;
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pss_dpath.sv @@
// ----------------------------------------------------------------------------
// pss_dpath
// Entry memory, element count, position arithmetic, bit-serial remainder
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_dpath
  import pss_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire pss_cmd_t                 cmd,
  output pss_stat_t                     stat,
  input  wire logic [KIND_W-1:0]        kind,
  input  wire logic signed [POS_W-1:0]  position,
  input  wire logic [VALUE_W-1:0]       value,
  output logic [VALUE_W-1:0]            read_value,
  output logic [STATUS_W-1:0]           status,
  output logic [COUNT_OUT_W-1:0]        element_count,
  output logic                          is_empty
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata;

  logic [KIND_W-1:0]     kind_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] value_r;

  logic [CW-1:0]         count;
  logic [CW-1:0]         at;
  logic [CW-1:0]         at_next;
  logic [CW-1:0]         idx;
  logic [CW-1:0]         idx_m1;
  logic [CW-1:0]         idx_p1;

  logic [CW-1:0]         rem;
  logic [CW:0]           rem_sh;
  logic [POS_W-1:0]      pshift;
  logic [MOD_CNT_W-1:0]  mcnt;

  logic                  wr_pend;
  logic [AW-1:0]         wr_addr;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;

  logic                  pos_neg;
  logic                  pos_zero;

  assign pos_neg  = pos_r[POS_W-1];
  assign pos_zero = (pos_r == '0);
  assign idx_m1   = idx - 1'b1;
  assign idx_p1   = idx + 1'b1;

  always_comb begin
    stat            = '0;
    stat.kind       = kind_r;
    stat.pos_neg    = pos_neg;
    stat.pos_pos    = !pos_neg && !pos_zero;
    stat.count_zero = (count == '0);
    stat.full       = (count >= CW'(CAPACITY));
    stat.up_done    = (idx == at);
    stat.dn_done    = ({1'b0, idx} + 1'b1) >= {1'b0, count};
    stat.mod_done   = (mcnt == MOD_CNT_W'(POS_W - 1));
  end

  // target position
  always_comb begin
    case (cmd.at_src)
      AT_CLAMP: begin
        if (pos_neg || pos_zero) begin
          at_next = '0;
        end else if (pos_r > POS_W'(count)) begin
          at_next = count;
        end else begin
          at_next = CW'(pos_r);
        end
      end
      AT_LAST: at_next = count - 1'b1;
      AT_HEAD: at_next = '0;
      default: at_next = rem;
    endcase
  end

  // one remainder bit per step: shift in the next position bit, subtract once
  assign rem_sh = {rem, pshift[POS_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= kind;
      pos_r   <= position;
      value_r <= DATA_WIDTH'(value);
    end
    if (cmd.at_load) begin
      at <= at_next;
    end
    if (cmd.idx_load) begin
      idx <= (cmd.idx_src == IDX_AT) ? at_next : count;
    end else if (cmd.shift_up) begin
      idx <= idx_m1;
    end else if (cmd.shift_dn) begin
      idx <= idx_p1;
    end
    if (cmd.mod_start) begin
      rem    <= '0;
      pshift <= pos_r;
      mcnt   <= '0;
    end else if (cmd.mod_step) begin
      rem    <= (rem_sh >= {1'b0, count}) ? CW'(rem_sh - {1'b0, count}) : CW'(rem_sh);
      pshift <= pshift << 1;
      mcnt   <= mcnt + 1'b1;
    end
    if (cmd.shift_up) begin
      wr_addr <= idx[AW-1:0];
    end else if (cmd.shift_dn) begin
      wr_addr <= idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= cmd.shift_up | cmd.shift_dn;
      if (cmd.count_clear) begin
        count <= '0;
      end else if (cmd.count_inc) begin
        count <= count + 1'b1;
      end else if (cmd.count_dec) begin
        count <= count - 1'b1;
      end
    end
  end

  // read issued in the cycle before the move that uses it
  always_comb begin
    rd_en   = cmd.shift_up | cmd.shift_dn | cmd.read_at;
    rd_addr = at[AW-1:0];
    if (cmd.shift_up) begin
      rd_addr = idx_m1[AW-1:0];
    end else if (cmd.shift_dn) begin
      rd_addr = idx_p1[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_pend) begin
      mem[wr_addr] <= rdata;
    end else if (cmd.write_value) begin
      mem[at[AW-1:0]] <= value_r;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      read_value    <= cmd.use_rdata ? VALUE_W'(rdata) : '0;
      status        <= cmd.status;
      element_count <= COUNT_OUT_W'(count);
      is_empty      <= (count == '0);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pss_chk.sv @@
// ----------------------------------------------------------------------------
// pss_chk
// Port-level checks for the positional sequence store, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_sequence_store_unit_macros.svh"

module pss_chk
  import pss_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [VALUE_W-1:0]       read_value,
  input wire logic [STATUS_W-1:0]      status,
  input wire logic [COUNT_OUT_W-1:0]   element_count,
  input wire logic                     is_empty
);

  `PSS_ASSERT_ALWAYS(a_rst_no_result, clk, rst |=> !out_valid, "result valid after reset")

  // only one transaction in flight on the input side
  `PSS_ASSERT(a_one_in_flight, clk, rst, in_valid && in_ready |=> !in_ready, "accepted twice in a row")

  `PSS_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(status) && $stable(element_count) && $stable(is_empty), "stalled result changed")

  `PSS_ASSERT(a_empty_status, clk, rst, out_valid && status == ST_EMPTY |-> is_empty && read_value == '0, "empty status inconsistent")

  `PSS_ASSERT(a_full_status, clk, rst, out_valid && status == ST_FULL |-> !is_empty && read_value == '0, "full status inconsistent")

endmodule

bind positional_sequence_store_unit pss_chk u_pss_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .read_value    (read_value),
  .status        (status),
  .element_count (element_count),
  .is_empty      (is_empty)
);

`default_nettype wire
